>>> hdl/bss_pkg.sv
// shared types, constants and codes for the band sweep sequencer
`default_nettype none

package bss_pkg;

  // number of points in one sweep
  localparam int POINTS = 200;
  // points counter holds POINTS itself
  localparam int PT_W = $clog2(POINTS + 1);
  // sample store address
  localparam int IDX_W = $clog2(POINTS);
  // signed window arithmetic: step times points plus sign and headroom
  localparam int ST_W = 16 + $clog2(POINTS) + 2;
  // shared divider: one quotient bit per cycle
  localparam int DIV_STEPS = 16;
  localparam int DCNT_W = $clog2(DIV_STEPS);

  localparam logic [6:0] SETTLE_FM = 7'd60;
  localparam logic [6:0] SETTLE_AM = 7'd80;
  localparam logic [7:0] TRK_LOW_INIT = 8'd255;
  localparam logic [7:0] TRK_HIGH_INIT = 8'd0;

  // configuration register indexes
  localparam logic [1:0] CFG_BAND_MIN = 2'd0;
  localparam logic [1:0] CFG_BAND_MAX = 2'd1;
  localparam logic [1:0] CFG_FM_MODE = 2'd2;

  typedef enum logic [2:0] {
    KIND_START   = 3'd0,
    KIND_ADVANCE = 3'd1,
    KIND_MEASURE = 3'd2,
    KIND_ABORT   = 3'd3,
    KIND_RESET   = 3'd4,
    KIND_READ    = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    SWP_OFF  = 2'd0,
    SWP_RUN  = 2'd1,
    SWP_DONE = 2'd2
  } sweep_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_START_INIT,
    DP_WIN_MULQ,
    DP_WIN_MULH,
    DP_WIN_MULS,
    DP_WIN_TOP,
    DP_WIN_BOT,
    DP_ADV_MUL,
    DP_ADV_CHK,
    DP_MEASURE,
    DP_ABORT,
    DP_CLEAR,
    DP_RD_DIV,
    DP_RD_ADDR,
    DP_RD_LVL_R,
    DP_RD_LVL_S,
    DP_RD_PUT_S
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_ST_DIV,
    S_ST_MULQ,
    S_ST_MULH,
    S_ST_MULS,
    S_ST_TOP,
    S_ST_BOT,
    S_ADV_MUL,
    S_ADV_CHK,
    S_RD_WAIT,
    S_RD_ADDR,
    S_RD_LVLR,
    S_RD_WAITR,
    S_RD_LVLS,
    S_RD_WAITS,
    S_RD_PUTS,
    S_RESULT
  } ctrl_state_t;

  // one input item
  typedef struct packed {
    kind_t       kind;
    logic [15:0] freq_value;
    logic [15:0] step_size;
    logic [7:0]  rssi_sample;
    logic [7:0]  snr_sample;
  } item_t;

  // one result item
  typedef struct packed {
    logic        tune_valid;
    logic [15:0] out_freq;
    logic [6:0]  settle_ms;
    logic [1:0]  sweep_status;
    logic        still_running;
    logic [15:0] rssi_level;
    logic [15:0] snr_level;
  } result_t;

  // controller to datapath
  typedef struct packed {
    dp_op_t op;
    logic   div_start;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  running;
    logic  div_done;
  } dp_status_t;

endpackage

`default_nettype wire

>>> hdl/bss_divider.sv
// shared restoring divider, one quotient bit per cycle
`default_nettype none

module bss_divider (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [15:0] rem_init,
  input  wire logic [15:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic [15:0]      quotient
);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [bss_pkg::DCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [15:0]                  rem_r, rem_nxt;
  logic [15:0]                  dvd_r, dvd_nxt;
  logic [15:0]                  dvs_r, dvs_nxt;
  logic [16:0]                  sh;
  logic                         ge;

  // one shift and trial subtract
  always_comb begin
    sh = {rem_r, dvd_r[15]};
    ge = (sh >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    dvs_nxt = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = '0;
      rem_nxt = rem_init;
      dvd_nxt = dividend;
      dvs_nxt = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? 16'(sh - {1'b0, dvs_r}) : sh[15:0];
      dvd_nxt = {dvd_r[14:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == bss_pkg::DCNT_W'(bss_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quotient = dvd_r;

endmodule

`default_nettype wire

>>> hdl/bss_datapath.sv
// sweep registers, sample store, multiplier and result fields
`default_nettype none

module bss_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [15:0]         cfg_wdata,
  input  wire bss_pkg::item_t      item,
  input  wire bss_pkg::dp_cmd_t    cmd,
  output bss_pkg::dp_status_t      status,
  output bss_pkg::result_t         result
);

  localparam int SW = bss_pkg::ST_W;

  // configuration
  logic [15:0] bmin_r, bmax_r;
  logic        fm_r;

  // sweep state
  bss_pkg::sweep_t          state_r, state_nxt;
  logic [15:0]              ws_r, ws_nxt;
  logic [15:0]              step_r, step_nxt;
  logic [bss_pkg::PT_W-1:0] pt_r, pt_nxt;
  logic [15:0]              home_r, home_nxt;
  logic [7:0]               rlo_r, rlo_nxt, rhi_r, rhi_nxt;
  logic [7:0]               slo_r, slo_nxt, shi_r, shi_nxt;
  logic [6:0]               settle_r, settle_nxt;

  // working registers
  bss_pkg::item_t           item_r, item_nxt;
  logic [31:0]              prod_r, prod_nxt;
  logic signed [SW-1:0]     st_r, st_nxt;
  logic                     hit_r, hit_nxt;
  logic                     use_r, use_nxt;
  logic [15:0]              rd_data_r;
  logic [15:0]              mem [bss_pkg::POINTS];

  // result fields
  logic        tv_r, tv_nxt;
  logic [15:0] freq_r, freq_nxt;
  logic [6:0]  set_r, set_nxt;
  logic        still_r, still_nxt;
  logic [15:0] rlev_r, rlev_nxt;
  logic [15:0] slev_r, slev_nxt;

  // shared divider
  logic        div_done;
  logic [15:0] div_q;
  logic [15:0] div_rem, div_dvd, div_dvs;

  logic [15:0]          step_eff;
  logic [15:0]          mul_b;
  logic [31:0]          prod_c;
  logic signed [SW-1:0] prod_s, bmin_s, bmax_s;
  logic [32:0]          adv_f;
  logic [7:0]           rd_rssi, rd_snr;
  logic                 pt_full;
  logic                 mem_we;
  logic [bss_pkg::PT_W-1:0] pt_inc;

  assign step_eff = (item_r.step_size == 16'd0) ? 16'd1 : item_r.step_size;
  assign prod_s   = SW'(signed'({1'b0, prod_r[SW-2:0]}));
  assign bmin_s   = signed'({(SW - 16)'(0), bmin_r});
  assign bmax_s   = signed'({(SW - 16)'(0), bmax_r});
  assign adv_f    = {17'd0, ws_r} + {1'b0, prod_r};
  assign rd_rssi  = rd_data_r[7:0];
  assign rd_snr   = rd_data_r[15:8];
  assign pt_full  = (pt_r >= bss_pkg::PT_W'(bss_pkg::POINTS));
  assign pt_inc   = pt_r + 1'b1;
  assign mem_we   = (cmd.op == bss_pkg::DP_MEASURE) && (state_r == bss_pkg::SWP_RUN) && !pt_full;

  // multiplier operand select
  always_comb begin
    case (cmd.op)
      bss_pkg::DP_WIN_MULQ: mul_b = div_q;
      bss_pkg::DP_WIN_MULH: mul_b = 16'(bss_pkg::POINTS / 2);
      bss_pkg::DP_WIN_MULS: mul_b = 16'(bss_pkg::POINTS - 1);
      bss_pkg::DP_ADV_MUL:  mul_b = 16'(pt_r);
      default:              mul_b = 16'd0;
    endcase
  end

  assign prod_c = {16'd0, step_r} * {16'd0, mul_b};

  // divider operand select
  always_comb begin
    div_rem = 16'd0;
    div_dvd = 16'd0;
    div_dvs = 16'd0;
    case (cmd.op)
      bss_pkg::DP_START_INIT: begin
        div_dvd = item_r.freq_value;
        div_dvs = step_eff;
      end
      bss_pkg::DP_RD_DIV: begin
        div_dvd = item_r.freq_value - ws_r;
        div_dvs = step_r;
      end
      bss_pkg::DP_RD_LVL_R: begin
        div_rem = {8'd0, 8'(rd_rssi - rlo_r)};
        div_dvs = {7'd0, 9'({1'b0, rhi_r} - {1'b0, rlo_r} + 9'd1)};
      end
      bss_pkg::DP_RD_LVL_S: begin
        div_rem = {8'd0, 8'(rd_snr - slo_r)};
        div_dvs = {7'd0, 9'({1'b0, shi_r} - {1'b0, slo_r} + 9'd1)};
      end
      default: begin
        div_rem = 16'd0;
      end
    endcase
  end

  bss_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .rem_init (div_rem),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // next values per operation
  always_comb begin
    state_nxt  = state_r;
    ws_nxt     = ws_r;
    step_nxt   = step_r;
    pt_nxt     = pt_r;
    home_nxt   = home_r;
    rlo_nxt    = rlo_r;
    rhi_nxt    = rhi_r;
    slo_nxt    = slo_r;
    shi_nxt    = shi_r;
    settle_nxt = settle_r;
    item_nxt   = item_r;
    prod_nxt   = prod_r;
    st_nxt     = st_r;
    hit_nxt    = hit_r;
    use_nxt    = use_r;
    tv_nxt     = tv_r;
    freq_nxt   = freq_r;
    set_nxt    = set_r;
    still_nxt  = still_r;
    rlev_nxt   = rlev_r;
    slev_nxt   = slev_r;
    case (cmd.op)
      bss_pkg::DP_LOAD: begin
        item_nxt  = item;
        tv_nxt    = 1'b0;
        freq_nxt  = 16'd0;
        set_nxt   = 7'd0;
        still_nxt = 1'b0;
        rlev_nxt  = 16'd0;
        slev_nxt  = 16'd0;
      end
      bss_pkg::DP_START_INIT: begin
        home_nxt   = item_r.freq_value;
        step_nxt   = step_eff;
        pt_nxt     = '0;
        rlo_nxt    = bss_pkg::TRK_LOW_INIT;
        rhi_nxt    = bss_pkg::TRK_HIGH_INIT;
        slo_nxt    = bss_pkg::TRK_LOW_INIT;
        shi_nxt    = bss_pkg::TRK_HIGH_INIT;
        state_nxt  = bss_pkg::SWP_RUN;
        settle_nxt = fm_r ? bss_pkg::SETTLE_FM : bss_pkg::SETTLE_AM;
      end
      // window start = step * quotient - step * half, then clamp
      bss_pkg::DP_WIN_MULQ: begin
        prod_nxt = prod_c;
      end
      bss_pkg::DP_WIN_MULH: begin
        st_nxt   = prod_s;
        prod_nxt = prod_c;
      end
      bss_pkg::DP_WIN_MULS: begin
        st_nxt   = st_r - prod_s;
        prod_nxt = prod_c;
      end
      bss_pkg::DP_WIN_TOP: begin
        if (st_r + prod_s > bmax_s) begin
          st_nxt = bmax_s - prod_s;
        end
      end
      bss_pkg::DP_WIN_BOT: begin
        ws_nxt = (st_r < bmin_s) ? bmin_r : st_r[15:0];
      end
      bss_pkg::DP_ADV_MUL: begin
        prod_nxt = prod_c;
      end
      bss_pkg::DP_ADV_CHK: begin
        if (state_r == bss_pkg::SWP_RUN) begin
          if (pt_full) begin
            state_nxt = bss_pkg::SWP_DONE;
          end else if ((adv_f < {17'd0, bmin_r}) || (adv_f > {17'd0, bmax_r})) begin
            state_nxt = bss_pkg::SWP_DONE;
          end else begin
            tv_nxt   = 1'b1;
            freq_nxt = adv_f[15:0];
            set_nxt  = settle_r;
          end
        end
      end
      bss_pkg::DP_MEASURE: begin
        if (state_r == bss_pkg::SWP_RUN && !pt_full) begin
          if (item_r.rssi_sample < rlo_r) rlo_nxt = item_r.rssi_sample;
          if (item_r.rssi_sample > rhi_r) rhi_nxt = item_r.rssi_sample;
          if (item_r.snr_sample < slo_r) slo_nxt = item_r.snr_sample;
          if (item_r.snr_sample > shi_r) shi_nxt = item_r.snr_sample;
          pt_nxt = pt_inc;
          if (pt_inc >= bss_pkg::PT_W'(bss_pkg::POINTS)) begin
            state_nxt = bss_pkg::SWP_DONE;
          end
        end else if (state_r == bss_pkg::SWP_RUN) begin
          state_nxt = bss_pkg::SWP_DONE;
        end
        still_nxt = (state_nxt == bss_pkg::SWP_RUN);
      end
      bss_pkg::DP_ABORT: begin
        if (state_r != bss_pkg::SWP_OFF) begin
          state_nxt = bss_pkg::SWP_OFF;
          freq_nxt  = home_r;
        end
      end
      bss_pkg::DP_CLEAR: begin
        state_nxt = bss_pkg::SWP_OFF;
      end
      // point index is ready: decide whether the point holds data
      bss_pkg::DP_RD_ADDR: begin
        hit_nxt = (state_r != bss_pkg::SWP_OFF) && (item_r.freq_value >= ws_r) &&
                  (step_r != 16'd0) && (div_q < {(16 - bss_pkg::PT_W)'(0), pt_r}) &&
                  (div_q < 16'(bss_pkg::POINTS));
      end
      bss_pkg::DP_RD_LVL_R: begin
        use_nxt = hit_r && (rhi_r > rlo_r) && (rd_rssi >= rlo_r);
      end
      bss_pkg::DP_RD_LVL_S: begin
        if (use_r) rlev_nxt = div_q;
        use_nxt = hit_r && (shi_r > slo_r) && (rd_snr >= slo_r);
      end
      bss_pkg::DP_RD_PUT_S: begin
        if (use_r) slev_nxt = div_q;
      end
      default: begin
        item_nxt = item_r;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bmin_r <= 16'd0;
      bmax_r <= 16'hFFFF;
      fm_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        bss_pkg::CFG_BAND_MIN: bmin_r <= cfg_wdata;
        bss_pkg::CFG_BAND_MAX: bmax_r <= cfg_wdata;
        bss_pkg::CFG_FM_MODE:  fm_r <= cfg_wdata[0];
        default:               fm_r <= fm_r;
      endcase
    end
  end

  // sweep state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bss_pkg::SWP_OFF;
      ws_r <= 16'd0;
      step_r <= 16'd0;
      pt_r <= '0;
      home_r <= 16'd0;
      rlo_r <= bss_pkg::TRK_LOW_INIT;
      rhi_r <= bss_pkg::TRK_HIGH_INIT;
      slo_r <= bss_pkg::TRK_LOW_INIT;
      shi_r <= bss_pkg::TRK_HIGH_INIT;
      settle_r <= bss_pkg::SETTLE_FM;
    end else begin
      state_r <= state_nxt;
      ws_r <= ws_nxt;
      step_r <= step_nxt;
      pt_r <= pt_nxt;
      home_r <= home_nxt;
      rlo_r <= rlo_nxt;
      rhi_r <= rhi_nxt;
      slo_r <= slo_nxt;
      shi_r <= shi_nxt;
      settle_r <= settle_nxt;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    prod_r <= prod_nxt;
    st_r <= st_nxt;
    hit_r <= hit_nxt;
    use_r <= use_nxt;
    tv_r <= tv_nxt;
    freq_r <= freq_nxt;
    set_r <= set_nxt;
    still_r <= still_nxt;
    rlev_r <= rlev_nxt;
    slev_r <= slev_nxt;
  end

  // sample store: rssi in the low byte, snr in the high byte
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pt_r[bss_pkg::IDX_W-1:0]] <= {item_r.snr_sample, item_r.rssi_sample};
    end
    if (cmd.op == bss_pkg::DP_RD_ADDR) begin
      rd_data_r <= mem[div_q[bss_pkg::IDX_W-1:0]];
    end
  end

  assign status.kind     = item_r.kind;
  assign status.running  = (state_r == bss_pkg::SWP_RUN);
  assign status.div_done = div_done;

  assign result.tune_valid    = tv_r;
  assign result.out_freq      = freq_r;
  assign result.settle_ms     = set_r;
  assign result.sweep_status  = state_r;
  assign result.still_running = still_r;
  assign result.rssi_level    = rlev_r;
  assign result.snr_level     = slev_r;

  // the point count never passes the sweep length
  a_pt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pt_r <= bss_pkg::PT_W'(bss_pkg::POINTS))
    else $error("point count beyond sweep length");

endmodule

`default_nettype wire

>>> hdl/bss_ctrl.sv
// item sequencer: steps the datapath through each item kind
`default_nettype none

module bss_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  input  wire logic                out_free,
  input  wire bss_pkg::dp_status_t status,
  output logic                     in_tready,
  output logic                     emit,
  output bss_pkg::dp_cmd_t         cmd
);

  bss_pkg::ctrl_state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bss_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = bss_pkg::S_DISPATCH;
      end
      bss_pkg::S_DISPATCH: begin
        case (status.kind)
          bss_pkg::KIND_START:   state_nxt = status.running ? bss_pkg::S_RESULT
                                                            : bss_pkg::S_ST_DIV;
          bss_pkg::KIND_ADVANCE: state_nxt = bss_pkg::S_ADV_MUL;
          bss_pkg::KIND_READ:    state_nxt = bss_pkg::S_RD_WAIT;
          default:               state_nxt = bss_pkg::S_RESULT;
        endcase
      end
      bss_pkg::S_ST_DIV:   if (status.div_done) state_nxt = bss_pkg::S_ST_MULQ;
      bss_pkg::S_ST_MULQ:  state_nxt = bss_pkg::S_ST_MULH;
      bss_pkg::S_ST_MULH:  state_nxt = bss_pkg::S_ST_MULS;
      bss_pkg::S_ST_MULS:  state_nxt = bss_pkg::S_ST_TOP;
      bss_pkg::S_ST_TOP:   state_nxt = bss_pkg::S_ST_BOT;
      bss_pkg::S_ST_BOT:   state_nxt = bss_pkg::S_RESULT;
      bss_pkg::S_ADV_MUL:  state_nxt = bss_pkg::S_ADV_CHK;
      bss_pkg::S_ADV_CHK:  state_nxt = bss_pkg::S_RESULT;
      bss_pkg::S_RD_WAIT:  if (status.div_done) state_nxt = bss_pkg::S_RD_ADDR;
      bss_pkg::S_RD_ADDR:  state_nxt = bss_pkg::S_RD_LVLR;
      bss_pkg::S_RD_LVLR:  state_nxt = bss_pkg::S_RD_WAITR;
      bss_pkg::S_RD_WAITR: if (status.div_done) state_nxt = bss_pkg::S_RD_LVLS;
      bss_pkg::S_RD_LVLS:  state_nxt = bss_pkg::S_RD_WAITS;
      bss_pkg::S_RD_WAITS: if (status.div_done) state_nxt = bss_pkg::S_RD_PUTS;
      bss_pkg::S_RD_PUTS:  state_nxt = bss_pkg::S_RESULT;
      bss_pkg::S_RESULT:   if (out_free) state_nxt = bss_pkg::S_IDLE;
      default:             state_nxt = bss_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    in_tready = 1'b0;
    emit = 1'b0;
    cmd.op = bss_pkg::DP_NOP;
    cmd.div_start = 1'b0;
    case (state_r)
      bss_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd.op = bss_pkg::DP_LOAD;
      end
      bss_pkg::S_DISPATCH: begin
        case (status.kind)
          bss_pkg::KIND_START: begin
            if (!status.running) begin
              cmd.op = bss_pkg::DP_START_INIT;
              cmd.div_start = 1'b1;
            end
          end
          bss_pkg::KIND_MEASURE: cmd.op = bss_pkg::DP_MEASURE;
          bss_pkg::KIND_ABORT:   cmd.op = bss_pkg::DP_ABORT;
          bss_pkg::KIND_RESET:   cmd.op = bss_pkg::DP_CLEAR;
          bss_pkg::KIND_READ: begin
            cmd.op = bss_pkg::DP_RD_DIV;
            cmd.div_start = 1'b1;
          end
          default: cmd.op = bss_pkg::DP_NOP;
        endcase
      end
      bss_pkg::S_ST_MULQ: cmd.op = bss_pkg::DP_WIN_MULQ;
      bss_pkg::S_ST_MULH: cmd.op = bss_pkg::DP_WIN_MULH;
      bss_pkg::S_ST_MULS: cmd.op = bss_pkg::DP_WIN_MULS;
      bss_pkg::S_ST_TOP:  cmd.op = bss_pkg::DP_WIN_TOP;
      bss_pkg::S_ST_BOT:  cmd.op = bss_pkg::DP_WIN_BOT;
      bss_pkg::S_ADV_MUL: cmd.op = bss_pkg::DP_ADV_MUL;
      bss_pkg::S_ADV_CHK: cmd.op = bss_pkg::DP_ADV_CHK;
      bss_pkg::S_RD_ADDR: cmd.op = bss_pkg::DP_RD_ADDR;
      bss_pkg::S_RD_LVLR: begin
        cmd.op = bss_pkg::DP_RD_LVL_R;
        cmd.div_start = 1'b1;
      end
      bss_pkg::S_RD_LVLS: begin
        cmd.op = bss_pkg::DP_RD_LVL_S;
        cmd.div_start = 1'b1;
      end
      bss_pkg::S_RD_PUTS: cmd.op = bss_pkg::DP_RD_PUT_S;
      bss_pkg::S_RESULT:  emit = out_free;
      default:            cmd.op = bss_pkg::DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bss_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // a transfer in always leads to dispatch
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == bss_pkg::S_DISPATCH))
    else $error("accepted item not dispatched");

  // a result leaves only while no item is being taken
  a_emit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !in_tready)
    else $error("result emitted while accepting");

  // after a result is handed over the sequencer is idle
  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (state_r == bss_pkg::S_IDLE))
    else $error("sequencer not idle after result");

endmodule

`default_nettype wire

>>> hdl/band_sweep_sequencer_unit.sv
// top level of the band sweep sequencer: stream ports and output register
`default_nettype none

// Bandscope sweep sequencer. Every input transfer yields exactly one result
// transfer. Items are handled one at a time; the next item is taken as soon
// as the result of the previous one sits in the output register, even while
// that register waits on out_tready. Path of each item from acceptance to the
// load of the output register: measure, abort, reset and reserved kinds go from
// dispatch straight to the result; advance adds a multiply and a check step;
// start adds a 16-bit quotient from the shared divider, then five multiply and
// clamp steps; read adds three passes through the shared divider (point index,
// RSSI level and SNR level) plus a registered store read and four setup steps.
// An item that finishes while the output register still holds an unaccepted
// result waits in its last cycle until that result is taken. The divider
// makes one quotient bit per cycle. No clearing pass is run after reset; stored
// points are read back only once measured.
module band_sweep_sequencer_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // freq_value[15:0], step_size[31:16], rssi_sample[39:32], snr_sample[47:40]
  input  wire logic [47:0] in_tdata,
  // kind[2:0]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_freq[15:0], settle_ms[22:16], sweep_status[24:23], still_running[25],
  // rssi_level[41:26], snr_level[57:42], zero fill[63:58]
  output logic [63:0]      out_tdata,
  // tune_valid[0]
  output logic             out_tuser
);

  bss_pkg::item_t      item;
  bss_pkg::dp_cmd_t    cmd;
  bss_pkg::dp_status_t status;
  bss_pkg::result_t    result;
  logic                emit;
  logic                out_free;
  logic                out_valid_r, out_valid_nxt;
  logic [63:0]         out_data_r;
  logic                out_user_r;

  // unpack the incoming transfer
  assign item.kind        = bss_pkg::kind_t'(in_tuser);
  assign item.freq_value  = in_tdata[15:0];
  assign item.step_size   = in_tdata[31:16];
  assign item.rssi_sample = in_tdata[39:32];
  assign item.snr_sample  = in_tdata[47:40];

  assign out_free = !out_valid_r || out_tready;

  bss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .out_free  (out_free),
    .status    (status),
    .in_tready (in_tready),
    .emit      (emit),
    .cmd       (cmd)
  );

  bss_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .item      (item),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= {6'd0, result.snr_level, result.rssi_level, result.still_running,
                     result.sweep_status, result.settle_ms, result.out_freq};
      out_user_r <= result.tune_valid;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

>>> dv/tb_band_sweep_sequencer_unit.sv
// testbench for the band sweep sequencer: directed and random items checked against a predictor
`timescale 1ns / 1ps

module tb_band_sweep_sequencer_unit;

  // kinds the block treats as no-ops
  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;
  localparam int RX_HOLD_CYCLES = 400;
  // a read is the slowest item
  localparam int DRAIN_CYCLES = 64;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = bss_pkg::CFG_BAND_MIN;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // freq_value[15:0], step_size[31:16], rssi_sample[39:32], snr_sample[47:40]
  logic [47:0] in_tdata = '0;
  // kind[2:0]
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // out_freq[15:0], settle_ms[22:16], sweep_status[24:23], still_running[25],
  // rssi_level[41:26], snr_level[57:42]
  logic [63:0] out_tdata;
  // tune_valid[0]
  logic        out_tuser;

  // predicted sweep state and register copies
  bss_pkg::sweep_t sw_state = bss_pkg::SWP_OFF;
  logic [15:0] win_base = '0;
  logic [15:0] sweep_step = '0;
  logic [15:0] home_freq_q = '0;
  int unsigned pts_taken = 0;
  logic [7:0]  rssi_lo = bss_pkg::TRK_LOW_INIT;
  logic [7:0]  rssi_hi = bss_pkg::TRK_HIGH_INIT;
  logic [7:0]  snr_lo = bss_pkg::TRK_LOW_INIT;
  logic [7:0]  snr_hi = bss_pkg::TRK_HIGH_INIT;
  logic [6:0]  settle_q = bss_pkg::SETTLE_FM;
  logic [15:0] band_lo = 16'd0;
  logic [15:0] band_hi = 16'hFFFF;
  logic        fm_sel = 1'b1;
  logic [7:0]  rssi_pts [bss_pkg::POINTS];
  logic [7:0]  snr_pts [bss_pkg::POINTS];

  bss_pkg::result_t results_due [$];
  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        rx_hold = 1'b0;

  band_sweep_sequencer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] rnd16();
    return 16'($urandom);
  endfunction

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  // q0.16 fraction of a sample within the tracked span, 9-bit span
  function automatic logic [15:0] q16_fraction(input logic [7:0] v, lo, hi);
    int unsigned span;
    if (hi <= lo || v < lo) return 16'd0;
    span = int'(hi) - int'(lo) + 1;
    return 16'((int'(v - lo) << 16) / span);
  endfunction

  // next result of the sweep sequencer; updates the predicted state
  function automatic bss_pkg::result_t sweep_predict(input logic [2:0] k,
                                                     input logic [15:0] fv, sv,
                                                     input logic [7:0] rs, sn);
    bss_pkg::result_t r;
    longint      ws, stp, span, f;
    int unsigned idx;
    r = '0;
    case (k)
      bss_pkg::KIND_START: begin
        if (sw_state != bss_pkg::SWP_RUN) begin
          home_freq_q = fv;
          sweep_step = (sv == 16'd0) ? 16'd1 : sv;
          pts_taken = 0;
          rssi_lo = bss_pkg::TRK_LOW_INIT;
          rssi_hi = bss_pkg::TRK_HIGH_INIT;
          snr_lo = bss_pkg::TRK_LOW_INIT;
          snr_hi = bss_pkg::TRK_HIGH_INIT;
          sw_state = bss_pkg::SWP_RUN;
          settle_q = fm_sel ? bss_pkg::SETTLE_FM : bss_pkg::SETTLE_AM;
          // align to the step grid, then pull the window into the band
          stp = longint'(sweep_step);
          span = stp * (bss_pkg::POINTS - 1);
          ws = stp * (longint'(fv / sweep_step) - bss_pkg::POINTS / 2);
          if (ws + span > longint'(band_hi)) ws = longint'(band_hi) - span;
          if (ws < longint'(band_lo)) ws = longint'(band_lo);
          win_base = ws[15:0];
        end
      end
      bss_pkg::KIND_ADVANCE: begin
        if (sw_state == bss_pkg::SWP_RUN) begin
          if (pts_taken >= bss_pkg::POINTS) begin
            sw_state = bss_pkg::SWP_DONE;
          end else begin
            // no wrap: anything past the band edge ends the sweep
            f = longint'(win_base) + longint'(sweep_step) * longint'(pts_taken);
            if (f < longint'(band_lo) || f > longint'(band_hi)) begin
              sw_state = bss_pkg::SWP_DONE;
            end else begin
              r.tune_valid = 1'b1;
              r.out_freq = f[15:0];
              r.settle_ms = settle_q;
            end
          end
        end
      end
      bss_pkg::KIND_MEASURE: begin
        if (sw_state == bss_pkg::SWP_RUN && pts_taken < bss_pkg::POINTS) begin
          rssi_pts[pts_taken] = rs;
          snr_pts[pts_taken] = sn;
          if (rs < rssi_lo) rssi_lo = rs;
          if (rs > rssi_hi) rssi_hi = rs;
          if (sn < snr_lo) snr_lo = sn;
          if (sn > snr_hi) snr_hi = sn;
          pts_taken++;
          if (pts_taken >= bss_pkg::POINTS) sw_state = bss_pkg::SWP_DONE;
        end else if (sw_state == bss_pkg::SWP_RUN) begin
          sw_state = bss_pkg::SWP_DONE;
        end
        r.still_running = (sw_state == bss_pkg::SWP_RUN);
      end
      bss_pkg::KIND_ABORT: begin
        if (sw_state != bss_pkg::SWP_OFF) begin
          sw_state = bss_pkg::SWP_OFF;
          r.out_freq = home_freq_q;
        end
      end
      bss_pkg::KIND_RESET: begin
        sw_state = bss_pkg::SWP_OFF;
      end
      bss_pkg::KIND_READ: begin
        if (sw_state != bss_pkg::SWP_OFF && fv >= win_base && sweep_step != 16'd0) begin
          idx = (fv - win_base) / sweep_step;
          if (idx < pts_taken && idx < bss_pkg::POINTS) begin
            r.rssi_level = q16_fraction(rssi_pts[idx], rssi_lo, rssi_hi);
            r.snr_level = q16_fraction(snr_pts[idx], snr_lo, snr_hi);
          end
        end
      end
      default: ;
    endcase
    r.sweep_status = sw_state;
    return r;
  endfunction

  // frequency inside a random point of the current window, up to span_pts
  function automatic logic [15:0] point_freq(input int unsigned span_pts);
    longint f;
    f = longint'(win_base) + longint'(sweep_step) * longint'($urandom_range(span_pts));
    if (sweep_step > 16'd1) f = f + longint'($urandom_range(sweep_step - 1));
    return f[15:0];
  endfunction

  // one input transfer; valid stays high on return
  task automatic send_item(input logic [2:0] k, input logic [15:0] fv, sv,
                           input logic [7:0] rs, sn);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser <= k;
    in_tdata <= {sn, rs, sv, fv};
    do @(posedge clk); while (!in_tready);
    results_due.push_back(sweep_predict(k, fv, sv, rs, sn));
    items_sent++;
  endtask

  // stop offering and wait for every pending result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write all three registers back to back; only while idle
  task automatic set_band(input logic [15:0] lo, hi, input logic fm);
    cfg_we <= 1'b1;
    cfg_index <= bss_pkg::CFG_BAND_MIN;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= bss_pkg::CFG_BAND_MAX;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_index <= bss_pkg::CFG_FM_MODE;
    cfg_wdata <= {15'd0, fm};
    @(posedge clk);
    cfg_we <= 1'b0;
    band_lo = lo;
    band_hi = hi;
    fm_sel = fm;
  endtask

  task automatic check_field(input string name, input logic [15:0] want, got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // result side: random ready, compare each transfer with the oldest prediction
  always @(posedge clk) begin
    bss_pkg::result_t want;
    if (out_tvalid && out_tready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual data %h tune %b",
                 $time, out_tdata, out_tuser);
        fail_count++;
      end else begin
        want = results_due.pop_front();
        check_field("tune_valid", 16'(want.tune_valid), 16'(out_tuser));
        check_field("out_freq", want.out_freq, out_tdata[15:0]);
        check_field("settle_ms", 16'(want.settle_ms), 16'(out_tdata[22:16]));
        check_field("sweep_status", 16'(want.sweep_status), 16'(out_tdata[24:23]));
        check_field("still_running", 16'(want.still_running), 16'(out_tdata[25]));
        check_field("rssi_level", want.rssi_level, out_tdata[41:26]);
        check_field("snr_level", want.snr_level, out_tdata[57:42]);
      end
    end
    out_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // idle-state kinds, reserved kinds, window clamps, flat trackers, band top
  task automatic test_directed_cases();
    set_band(16'd0, 16'hFFFF, 1'b1);
    send_item(bss_pkg::KIND_ADVANCE, 16'd0, 16'd0, 8'd0, 8'd0);
    send_item(bss_pkg::KIND_MEASURE, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    send_item(bss_pkg::KIND_ABORT, 16'd0, 16'd0, 8'd0, 8'd0);
    send_item(bss_pkg::KIND_READ, 16'd0, 16'd0, 8'd0, 8'd0);
    send_item(KIND_SPARE_LO, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    send_item(KIND_SPARE_HI, 16'hA5A5, 16'h5A5A, 8'hA5, 8'h5A);
    // zero step at the top of the band: window pulled down to end at the edge
    send_item(bss_pkg::KIND_START, 16'hFFFF, 16'd0, 8'd0, 8'd0);
    send_item(bss_pkg::KIND_START, 16'd0, 16'hFFFF, 8'd0, 8'd0);
    send_item(bss_pkg::KIND_READ, 16'd0, 16'd0, 8'd0, 8'd0);
    send_item(bss_pkg::KIND_READ, win_base, 16'd0, 8'd0, 8'd0);
    // measure with no advance before it
    send_item(bss_pkg::KIND_MEASURE, 16'd0, 16'd0, 8'd0, 8'd255);
    send_item(bss_pkg::KIND_ADVANCE, 16'd0, 16'd0, 8'd0, 8'd0);
    send_item(bss_pkg::KIND_MEASURE, 16'd0, 16'd0, 8'd255, 8'd0);
    send_item(bss_pkg::KIND_READ, win_base, 16'd0, 8'd0, 8'd0);
    send_item(bss_pkg::KIND_ABORT, 16'd0, 16'd0, 8'd0, 8'd0);
    // huge step: window below the band floor, third point lands past 16 bits
    send_item(bss_pkg::KIND_START, 16'd0, 16'hFFFF, 8'd0, 8'd0);
    send_item(bss_pkg::KIND_ADVANCE, 16'd0, 16'd0, 8'd0, 8'd0);
    send_item(bss_pkg::KIND_MEASURE, 16'd0, 16'd0, 8'd7, 8'd7);
    send_item(bss_pkg::KIND_ADVANCE, 16'd0, 16'd0, 8'd0, 8'd0);
    send_item(bss_pkg::KIND_MEASURE, 16'd0, 16'd0, 8'd7, 8'd7);
    send_item(bss_pkg::KIND_READ, 16'd0, 16'd0, 8'd0, 8'd0);
    send_item(bss_pkg::KIND_ADVANCE, 16'd0, 16'd0, 8'd0, 8'd0);
    send_item(bss_pkg::KIND_MEASURE, 16'd0, 16'd0, 8'd1, 8'd1);
    send_item(bss_pkg::KIND_READ, 16'hFFFF, 16'd0, 8'd0, 8'd0);
    send_item(bss_pkg::KIND_RESET, 16'd0, 16'd0, 8'd0, 8'd0);
    send_item(bss_pkg::KIND_READ, 16'hFFFF, 16'd0, 8'd0, 8'd0);
  endtask

  // every point of one sweep taken, am settle time
  task automatic test_full_sweep();
    drain_results();
    set_band(16'd0, 16'hFFFF, 1'b0);
    send_item(bss_pkg::KIND_START, rnd16(), 16'($urandom_range(1, 329)), rnd8(), rnd8());
    repeat (bss_pkg::POINTS) begin
      if ($urandom_range(1))
        send_item(bss_pkg::KIND_ADVANCE, rnd16(), rnd16(), rnd8(), rnd8());
      send_item(bss_pkg::KIND_MEASURE, rnd16(), rnd16(), rnd8(), rnd8());
    end
    send_item(bss_pkg::KIND_ADVANCE, rnd16(), rnd16(), rnd8(), rnd8());
    repeat (6)
      send_item(bss_pkg::KIND_READ, point_freq(bss_pkg::POINTS), rnd16(), rnd8(), rnd8());
    send_item(bss_pkg::KIND_ABORT, rnd16(), rnd16(), rnd8(), rnd8());
  endtask

  // narrow, empty and inverted bands so sweeps run into the edges
  task automatic test_band_edges();
    logic [15:0] lo, hi;
    for (int n = 0; n < 14; n++) begin
      case (n)
        0: begin lo = 16'd0; hi = 16'd0; end
        1: begin lo = 16'hFFFF; hi = 16'hFFFF; end
        2: begin lo = 16'hFFFF; hi = 16'd0; end
        3: begin lo = 16'd1000; hi = 16'd1500; end
        default: begin
          lo = rnd16();
          hi = lo + 16'($urandom_range(3000));
        end
      endcase
      drain_results();
      set_band(lo, hi, n[0]);
      send_item(bss_pkg::KIND_START, lo + 16'($urandom_range(400)), 16'($urandom_range(400)),
                rnd8(), rnd8());
      for (int p = 0; p < 24 && sw_state == bss_pkg::SWP_RUN; p++) begin
        send_item(bss_pkg::KIND_ADVANCE, rnd16(), rnd16(), rnd8(), rnd8());
        if (sw_state == bss_pkg::SWP_RUN)
          send_item(bss_pkg::KIND_MEASURE, rnd16(), rnd16(), rnd8(), rnd8());
      end
      send_item(bss_pkg::KIND_READ, point_freq(pts_taken), rnd16(), rnd8(), rnd8());
      send_item($urandom_range(1) ? bss_pkg::KIND_ABORT : bss_pkg::KIND_RESET,
                rnd16(), rnd16(), rnd8(), rnd8());
    end
  endtask

  // sweeps with random content, some noise and broken sequences
  task automatic test_random_sweeps(input int unsigned n_items);
    int unsigned stop_at, sweeps, roll;
    stop_at = items_sent + n_items;
    sweeps = 0;
    while (items_sent < stop_at) begin
      // new band every few sweeps, mostly wide
      if (sweeps % 4 == 0) begin
        drain_results();
        if ($urandom_range(99) < 60)
          set_band(16'($urandom_range(2000)), 16'($urandom_range(60000, 65535)), 1'($urandom));
        else
          set_band(rnd16(), rnd16(), 1'($urandom));
      end
      sweeps++;
      send_item(bss_pkg::KIND_START, rnd16(),
                ($urandom_range(9) == 0) ? rnd16() : 16'($urandom_range(300)), rnd8(), rnd8());
      repeat ($urandom_range(3, 60)) begin
        roll = $urandom_range(99);
        if (roll < 38)
          send_item(bss_pkg::KIND_ADVANCE, rnd16(), rnd16(), rnd8(), rnd8());
        else if (roll < 75)
          send_item(bss_pkg::KIND_MEASURE, rnd16(), rnd16(), rnd8(), rnd8());
        else if (roll < 88)
          send_item(bss_pkg::KIND_READ, point_freq(pts_taken + 1), rnd16(), rnd8(), rnd8());
        else if (roll < 91)
          send_item(bss_pkg::KIND_READ, rnd16(), rnd16(), rnd8(), rnd8());
        else if (roll < 93)
          send_item(bss_pkg::KIND_START, rnd16(), rnd16(), rnd8(), rnd8());
        else if (roll < 95)
          send_item($urandom_range(1) ? KIND_SPARE_LO : KIND_SPARE_HI,
                    rnd16(), rnd16(), rnd8(), rnd8());
        else if (roll < 97)
          send_item(bss_pkg::KIND_ABORT, rnd16(), rnd16(), rnd8(), rnd8());
        else if (roll < 98)
          send_item(bss_pkg::KIND_RESET, rnd16(), rnd16(), rnd8(), rnd8());
        else
          send_item(3'($urandom_range(7)), rnd16(), rnd16(), rnd8(), rnd8());
      end
      // end the sweep by abort, reset, or let it be
      roll = $urandom_range(99);
      if (roll < 50)
        send_item(bss_pkg::KIND_ABORT, rnd16(), rnd16(), rnd8(), rnd8());
      else if (roll < 70)
        send_item(bss_pkg::KIND_RESET, rnd16(), rnd16(), rnd8(), rnd8());
    end
  endtask

  // result side held off while items keep coming, so the input stalls
  task automatic test_output_backpressure();
    drain_results();
    fork
      begin
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    send_item(bss_pkg::KIND_START, rnd16(), 16'($urandom_range(1, 300)), rnd8(), rnd8());
    repeat (30)
      send_item($urandom_range(1) ? bss_pkg::KIND_ADVANCE : bss_pkg::KIND_MEASURE,
                rnd16(), rnd16(), rnd8(), rnd8());
    drain_results();
  endtask

  // test sequence
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 22;
    recv_idle_pct = 58;
    test_directed_cases();
    test_full_sweep();
    send_idle_pct = 58;
    recv_idle_pct = 22;
    test_band_edges();
    test_random_sweeps(300);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_sweeps(300);
    test_output_backpressure();
    drain_results();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
